// ----- rtl/display_idle_wake_key_filter_unit_assert.svh -----
// Assertion macros shared by the display idle / wake key filter RTL.
// Expects a clock named clk and a synchronous active-high reset named rst.
`ifndef DISPLAY_IDLE_WAKE_KEY_FILTER_UNIT_ASSERT_SVH
`define DISPLAY_IDLE_WAKE_KEY_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DIWKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DIWKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/diwkf_pkg.sv -----
// Package for the display idle / wake key filter: codes, payload types, reset values.
// No dependencies.
package diwkf_pkg;

  localparam int NUM_BUTTONS_DEF = 3;
  localparam int COUNT_W         = 16;
  localparam int BUTTON_W        = 2;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [COUNT_W-1:0]  TIMEOUT_RESET    = 16'd600;
  localparam logic [BUTTON_W-1:0] OFF_BUTTON_RESET = 2'd0;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_KEY      = 3'd1,
    OP_DROPPED  = 3'd2,
    OP_ACTIVITY = 3'd3,
    OP_OFF      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_CLICK   = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_LONG    = 3'd4,
    EV_GEND    = 3'd5
  } ev_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_TICKS = 2'd0,
    REG_OFF_BUTTON    = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]          operation;
    logic [BUTTON_W-1:0] button;
    logic [2:0]          event_code;
    logic                busy_now;
  } item_t;

  typedef struct packed {
    logic consumed;
    logic display_off;
    logic woke;
    logic went_off;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  timeout_ticks;
    logic [BUTTON_W-1:0] off_button;
  } cfg_t;

endpackage

// ----- rtl/diwkf_if.sv -----
// Channel interfaces: input items, result items and configuration writes.
// Depends on diwkf_pkg.
interface diwkf_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    operation;
  logic [diwkf_pkg::BUTTON_W-1:0] button;
  logic [2:0]                    event_code;
  logic                          busy_now;

  modport source (output valid, operation, button, event_code, busy_now, input ready);
  modport sink   (input valid, operation, button, event_code, busy_now, output ready);
endinterface

interface diwkf_out_if;
  logic valid;
  logic ready;
  logic consumed;
  logic display_off;
  logic woke;
  logic went_off;

  modport source (output valid, consumed, display_off, woke, went_off, input ready);
  modport sink   (input valid, consumed, display_off, woke, went_off, output ready);
endinterface

interface diwkf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [diwkf_pkg::CFG_INDEX_W-1:0] index;
  logic [diwkf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/display_idle_wake_key_filter_unit.sv -----
// Display idle timeout and key filter, top level.
// Depends on diwkf_pkg, the channel interfaces, diwkf_step and the assertion header.
//
// Usage:
//   in_ch  : items (operation, button, event_code, busy_now); valid/ready.
//   out_ch : one result per item (consumed, display_off, woke, went_off).
//   cfg    : register writes; index 0 timeout_ticks, index 1 off_button,
//            other indexes ignored. Always ready; write only while idle.
// Path: an accepted transaction passes through the input register, then the
//   result register, before its result shows on out_ch.
// Throughput: one item per cycle while out_ch.ready holds; the only state
//   path is the update of the masks, off flag and 16-bit idle counter in diwkf_step.
// Stall: the input register and result register form two stages; with the
//   receiver stalled both fill, then in_ch.ready drops. Nothing is lost.
// Reset: rst (synchronous, active high) empties both stages, clears the
//   held and guard masks, the idle counter and the off flag, and restores
//   timeout_ticks to 600 and off_button to 0.
`include "display_idle_wake_key_filter_unit_assert.svh"

module display_idle_wake_key_filter_unit #(
  parameter int NUM_BUTTONS = diwkf_pkg::NUM_BUTTONS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  diwkf_in_if.sink    in_ch,
  diwkf_out_if.source out_ch,
  diwkf_cfg_if.sink   cfg
);

  // Configuration registers.
  diwkf_pkg::cfg_t cfg_reg;

  // Input stage.
  logic             s1_valid;
  diwkf_pkg::item_t s1_item;

  // Output stage.
  logic               out_valid;
  diwkf_pkg::result_t out_res;

  // Filter state.
  logic [NUM_BUTTONS-1:0]        held;
  logic [NUM_BUTTONS-1:0]        guard;
  logic                          is_off;
  logic [diwkf_pkg::COUNT_W-1:0] idle_count;

  logic [NUM_BUTTONS-1:0]        held_next;
  logic [NUM_BUTTONS-1:0]        guard_next;
  logic                          is_off_next;
  logic [diwkf_pkg::COUNT_W-1:0] idle_count_next;
  diwkf_pkg::result_t            res_next;

  logic advance;
  logic in_fire;

  // Move the input stage forward whenever the result register is free
  // or being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || !out_valid || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg.ready = 1'b1;

  assign out_ch.valid       = out_valid;
  assign out_ch.consumed    = out_res.consumed;
  assign out_ch.display_off = out_res.display_off;
  assign out_ch.woke        = out_res.woke;
  assign out_ch.went_off    = out_res.went_off;

  diwkf_step #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_step (
    .item            (s1_item),
    .cfg             (cfg_reg),
    .held            (held),
    .guard           (guard),
    .is_off          (is_off),
    .idle_count      (idle_count),
    .held_next       (held_next),
    .guard_next      (guard_next),
    .is_off_next     (is_off_next),
    .idle_count_next (idle_count_next),
    .res             (res_next)
  );

  // Configuration writes; out-of-list indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.timeout_ticks <= diwkf_pkg::TIMEOUT_RESET;
      cfg_reg.off_button    <= diwkf_pkg::OFF_BUTTON_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        diwkf_pkg::REG_TIMEOUT_TICKS:
          cfg_reg.timeout_ticks <= cfg.data[diwkf_pkg::COUNT_W-1:0];
        diwkf_pkg::REG_OFF_BUTTON:
          cfg_reg.off_button <= cfg.data[diwkf_pkg::BUTTON_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the item until it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.operation  <= in_ch.operation;
      s1_item.button     <= in_ch.button;
      s1_item.event_code <= in_ch.event_code;
      s1_item.busy_now   <= in_ch.busy_now;
    end
  end

  // Commit state and load the result register as the item advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      guard      <= '0;
      is_off     <= 1'b0;
      idle_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        held       <= held_next;
        guard      <= guard_next;
        is_off     <= is_off_next;
        idle_count <= idle_count_next;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // A result that turns the display off must report it off.
  `DIWKF_ASSERT_NOW(a_went_off_reports_off, out_valid && out_res.went_off,
    out_res.display_off, "went_off without display_off")

  // Waking and turning off never happen on the same item.
  `DIWKF_ASSERT_NOW(a_wake_off_exclusive, out_valid, !(out_res.woke && out_res.went_off),
    "woke and went_off both set")

  // Only key events can be swallowed.
  `DIWKF_ASSERT_NOW(a_consume_key_only,
    advance && (s1_item.operation != diwkf_pkg::OP_KEY), !res_next.consumed,
    "consumed set on a non-key item")

  // The off flag follows the item that turned the display off.
  `DIWKF_ASSERT_NEXT(a_off_follows, advance && res_next.went_off, is_off,
    "display not off after went_off")

  // Waking clears the idle counter.
  `DIWKF_ASSERT_NEXT(a_wake_clears_count, advance && res_next.woke, idle_count == '0,
    "idle counter not cleared on wake")

endmodule

// ----- rtl/diwkf_step.sv -----
// Next-state and result logic for one item of the display idle / wake key filter.
// Depends on diwkf_pkg.
module diwkf_step #(
  parameter int NUM_BUTTONS = diwkf_pkg::NUM_BUTTONS_DEF
) (
  input  diwkf_pkg::item_t                  item,
  input  diwkf_pkg::cfg_t                   cfg,
  input  logic [NUM_BUTTONS-1:0]            held,
  input  logic [NUM_BUTTONS-1:0]            guard,
  input  logic                              is_off,
  input  logic [diwkf_pkg::COUNT_W-1:0]     idle_count,
  output logic [NUM_BUTTONS-1:0]            held_next,
  output logic [NUM_BUTTONS-1:0]            guard_next,
  output logic                              is_off_next,
  output logic [diwkf_pkg::COUNT_W-1:0]     idle_count_next,
  output diwkf_pkg::result_t                res
);

  logic                          in_range;
  logic [NUM_BUTTONS-1:0]        btn_bit;
  logic [diwkf_pkg::COUNT_W-1:0] count_inc;

  assign in_range  = (int'(item.button) < NUM_BUTTONS);
  assign btn_bit   = in_range ? (NUM_BUTTONS'(1) << item.button) : '0;
  assign count_inc = (idle_count != '1) ? idle_count + 1'b1 : idle_count;

  always_comb begin
    held_next       = held;
    guard_next      = guard;
    is_off_next     = is_off;
    idle_count_next = idle_count;
    res             = '0;

    unique case (item.operation)
      diwkf_pkg::OP_TICK: begin
        if (!is_off) begin
          if ((|held) || item.busy_now) begin
            idle_count_next = '0;
          end else begin
            idle_count_next = count_inc;
            if (count_inc >= cfg.timeout_ticks) begin
              is_off_next  = 1'b1;
              res.went_off = 1'b1;
            end
          end
        end
      end
      diwkf_pkg::OP_KEY: begin
        if (in_range) begin
          idle_count_next = '0;
          case (item.event_code) inside
            diwkf_pkg::EV_PRESS: begin
              held_next = held | btn_bit;
              if (is_off) begin
                guard_next  = guard | btn_bit;
                is_off_next = 1'b0;
                res.woke    = 1'b1;
              end
              res.consumed = |(guard_next & btn_bit);
            end
            diwkf_pkg::EV_RELEASE: begin
              held_next    = held & ~btn_bit;
              res.consumed = 1'b1;
            end
            diwkf_pkg::EV_GEND: begin
              held_next    = held & ~btn_bit;
              guard_next   = guard & ~btn_bit;
              res.consumed = 1'b1;
            end
            diwkf_pkg::EV_CLICK, diwkf_pkg::EV_DOUBLE, diwkf_pkg::EV_LONG: begin
              if (is_off) begin
                // Any gesture wakes a dark display and is swallowed.
                is_off_next  = 1'b0;
                res.woke     = 1'b1;
                res.consumed = 1'b1;
              end else if (|(guard & btn_bit)) begin
                res.consumed = 1'b1;
              end else if ((item.event_code == diwkf_pkg::EV_LONG) &&
                           (item.button == cfg.off_button)) begin
                is_off_next  = 1'b1;
                res.went_off = 1'b1;
                res.consumed = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      diwkf_pkg::OP_DROPPED: begin
        if (item.event_code == diwkf_pkg::EV_RELEASE) begin
          held_next = held & ~btn_bit;
        end else if (item.event_code == diwkf_pkg::EV_GEND) begin
          held_next  = held & ~btn_bit;
          guard_next = guard & ~btn_bit;
        end
      end
      diwkf_pkg::OP_ACTIVITY: begin
        idle_count_next = '0;
      end
      diwkf_pkg::OP_OFF: begin
        if (!is_off) begin
          is_off_next  = 1'b1;
          res.went_off = 1'b1;
        end
      end
      default: ;
    endcase

    res.display_off = is_off_next;
  end

endmodule
